// ===== design/bmlc_pkg.sv =====
// Shared types and constants for the button mode LED controller.
`default_nettype none

package bmlc_pkg;

    // Light modes
    localparam logic [2:0] MODE_FULL    = 3'd0;
    localparam logic [2:0] MODE_MEDIUM  = 3'd1;
    localparam logic [2:0] MODE_LOW     = 3'd2;
    localparam logic [2:0] MODE_BLINK_A = 3'd3;
    localparam logic [2:0] MODE_BLINK_B = 3'd4;
    localparam logic [2:0] MODE_FADE    = 3'd5;
    localparam logic [2:0] MODE_BLINK_C = 3'd6;
    localparam logic [2:0] MODE_OFF     = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] CFG_LONG_PRESS  = 3'd1;
    localparam logic [2:0] CFG_MEDIUM      = 3'd2;
    localparam logic [2:0] CFG_LOW         = 3'd3;
    localparam logic [2:0] CFG_FADE_PERIOD = 3'd4;
    localparam logic [2:0] CFG_FADE_STEP   = 3'd5;

    // Field and counter widths
    localparam int PRESS_AGE_W = 14;
    localparam int BLINK_AGE_W = 11;
    localparam int BYTE_W      = 8;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 3;

    // Blink on and off times in ticks
    localparam logic [BLINK_AGE_W-1:0] BLINK_A_ON  = 11'd600;
    localparam logic [BLINK_AGE_W-1:0] BLINK_A_OFF = 11'd900;
    localparam logic [BLINK_AGE_W-1:0] BLINK_B_ON  = 11'd200;
    localparam logic [BLINK_AGE_W-1:0] BLINK_B_OFF = 11'd300;
    localparam logic [BLINK_AGE_W-1:0] BLINK_C_ON  = 11'd60;
    localparam logic [BLINK_AGE_W-1:0] BLINK_C_OFF = 11'd1500;

    localparam logic [BYTE_W-1:0] DUTY_FULL = 8'd255;
    localparam logic [BYTE_W-1:0] DUTY_DARK = 8'd0;

    // Button stage outcome for one tick, handed to the light stage
    typedef struct packed {
        logic              awake;
        logic              sleeping;
        logic [MODE_W-1:0] mode;
        logic              strobe;
        logic [MODE_W-1:0] saved;
    } t_btn_status;

endpackage

`default_nettype wire

// ===== design/bmlc_button.sv =====
// Button handling: wake, debounce sampling, long and short press, mode state.
`default_nettype none

module bmlc_button (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_advance,
    input  wire logic                                 i_pressed,
    input  wire logic [bmlc_pkg::BYTE_W-1:0]          i_debounce_ms,
    input  wire logic [bmlc_pkg::PRESS_AGE_W-1:0]     i_long_press_ms,
    output bmlc_pkg::t_btn_status                     o_status
);

    logic                                r_sleeping, n_sleeping;
    logic [bmlc_pkg::MODE_W-1:0]         r_mode, n_mode;
    logic [bmlc_pkg::MODE_W-1:0]         r_stored, n_stored;
    logic                                r_armed, n_armed;
    logic                                r_btn_latched, n_btn_latched;
    logic                                r_long_latched, n_long_latched;
    logic [bmlc_pkg::PRESS_AGE_W-1:0]    r_press_age, n_press_age;
    logic [bmlc_pkg::BYTE_W-1:0]         r_sample_age, n_sample_age;

    // Work out the next button state for the tick in the input register
    always_comb begin
        logic awake;
        logic strobe;
        logic [bmlc_pkg::MODE_W-1:0] saved;

        awake          = !r_sleeping || i_pressed;
        strobe         = 1'b0;
        saved          = '0;
        n_sleeping     = r_sleeping;
        n_mode         = r_mode;
        n_stored       = r_stored;
        n_armed        = r_armed;
        n_btn_latched  = r_btn_latched;
        n_long_latched = r_long_latched;
        n_press_age    = r_press_age;
        n_sample_age   = r_sample_age;

        // Wake on a press: reload the stored mode and drop the arm mark
        if (r_sleeping && i_pressed) begin
            n_mode     = r_stored;
            n_armed    = 1'b0;
            n_sleeping = 1'b0;
        end

        if (awake) begin
            if (r_press_age != {bmlc_pkg::PRESS_AGE_W{1'b1}}) begin
                n_press_age = r_press_age + 1'b1;
            end

            if (r_sample_age >= i_debounce_ms) begin
                n_sample_age = '0;
                // Start of a press
                if (i_pressed && !r_btn_latched && !r_long_latched) begin
                    n_press_age   = '0;
                    n_btn_latched = 1'b1;
                end
                // Long press: step the mode modulo 7
                if (i_pressed && !r_long_latched && n_press_age >= i_long_press_ms) begin
                    n_long_latched = 1'b1;
                    case (n_mode)
                        bmlc_pkg::MODE_BLINK_C: n_mode = bmlc_pkg::MODE_FULL;
                        bmlc_pkg::MODE_OFF:     n_mode = bmlc_pkg::MODE_MEDIUM;
                        default:                n_mode = n_mode + 1'b1;
                    endcase
                    n_armed = 1'b1;
                end
                // Release: a short one stores and sleeps, or only arms
                if (!i_pressed && r_btn_latched) begin
                    n_btn_latched  = 1'b0;
                    n_long_latched = 1'b0;
                    if (n_press_age < i_long_press_ms) begin
                        if (n_armed) begin
                            n_stored   = n_mode;
                            strobe     = 1'b1;
                            saved      = n_mode;
                            n_mode     = bmlc_pkg::MODE_OFF;
                            n_sleeping = 1'b1;
                        end else begin
                            n_armed = 1'b1;
                        end
                    end
                end
            end else begin
                n_sample_age = r_sample_age + 1'b1;
            end
        end

        o_status.awake    = awake;
        o_status.sleeping = n_sleeping;
        o_status.mode     = n_mode;
        o_status.strobe   = strobe;
        o_status.saved    = saved;
    end

    // Commit the state on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleeping     <= 1'b1;
            r_mode         <= bmlc_pkg::MODE_OFF;
            r_stored       <= bmlc_pkg::MODE_FULL;
            r_armed        <= 1'b0;
            r_btn_latched  <= 1'b0;
            r_long_latched <= 1'b0;
            r_press_age    <= '0;
            r_sample_age   <= '0;
        end else if (i_advance) begin
            r_sleeping     <= n_sleeping;
            r_mode         <= n_mode;
            r_stored       <= n_stored;
            r_armed        <= n_armed;
            r_btn_latched  <= n_btn_latched;
            r_long_latched <= n_long_latched;
            r_press_age    <= n_press_age;
            r_sample_age   <= n_sample_age;
        end
    end

endmodule

`default_nettype wire

// ===== design/bmlc_light.sv =====
// Light generation: fixed levels, blink patterns and triangle fade.
`default_nettype none

module bmlc_light (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_advance,
    input  wire bmlc_pkg::t_btn_status             i_status,
    input  wire logic [bmlc_pkg::BYTE_W-1:0]       i_medium_level,
    input  wire logic [bmlc_pkg::BYTE_W-1:0]       i_low_level,
    input  wire logic [bmlc_pkg::BYTE_W-1:0]       i_fade_period_ms,
    input  wire logic [bmlc_pkg::BYTE_W-1:0]       i_fade_step,
    output logic      [bmlc_pkg::BYTE_W-1:0]       o_duty
);

    logic                               r_blink_lit, n_blink_lit;
    logic [bmlc_pkg::BLINK_AGE_W-1:0]   r_blink_age, n_blink_age;
    logic [bmlc_pkg::BYTE_W-1:0]        r_fade_level, n_fade_level;
    logic                               r_fade_falling, n_fade_falling;
    logic [bmlc_pkg::BYTE_W-1:0]        r_fade_age, n_fade_age;
    logic [bmlc_pkg::BYTE_W-1:0]        r_duty, n_duty;

    // Next light state for the mode in force after the button sample
    always_comb begin
        logic                             blinking;
        logic [bmlc_pkg::BLINK_AGE_W-1:0] on_time;
        logic [bmlc_pkg::BLINK_AGE_W-1:0] off_time;

        blinking       = 1'b0;
        on_time        = bmlc_pkg::BLINK_A_ON;
        off_time       = bmlc_pkg::BLINK_A_OFF;
        n_blink_lit    = r_blink_lit;
        n_blink_age    = r_blink_age;
        n_fade_level   = r_fade_level;
        n_fade_falling = r_fade_falling;
        n_fade_age     = r_fade_age;
        n_duty         = r_duty;

        if (i_status.awake) begin
            if (r_blink_age != {bmlc_pkg::BLINK_AGE_W{1'b1}}) begin
                n_blink_age = r_blink_age + 1'b1;
            end
            if (r_fade_age != {bmlc_pkg::BYTE_W{1'b1}}) begin
                n_fade_age = r_fade_age + 1'b1;
            end

            case (i_status.mode)
                bmlc_pkg::MODE_FULL:   n_duty = bmlc_pkg::DUTY_FULL;
                bmlc_pkg::MODE_MEDIUM: n_duty = i_medium_level;
                bmlc_pkg::MODE_LOW:    n_duty = i_low_level;
                bmlc_pkg::MODE_BLINK_A: begin
                    blinking = 1'b1;
                    on_time  = bmlc_pkg::BLINK_A_ON;
                    off_time = bmlc_pkg::BLINK_A_OFF;
                end
                bmlc_pkg::MODE_BLINK_B: begin
                    blinking = 1'b1;
                    on_time  = bmlc_pkg::BLINK_B_ON;
                    off_time = bmlc_pkg::BLINK_B_OFF;
                end
                bmlc_pkg::MODE_BLINK_C: begin
                    blinking = 1'b1;
                    on_time  = bmlc_pkg::BLINK_C_ON;
                    off_time = bmlc_pkg::BLINK_C_OFF;
                end
                bmlc_pkg::MODE_FADE: begin
                    // Step the triangle and flip direction at either end
                    if (n_fade_age >= i_fade_period_ms) begin
                        n_fade_age = '0;
                        n_duty     = r_fade_level;
                        if (r_fade_falling) begin
                            n_fade_level = r_fade_level - i_fade_step;
                        end else begin
                            n_fade_level = r_fade_level + i_fade_step;
                        end
                        if (n_fade_level == '0 || n_fade_level == {bmlc_pkg::BYTE_W{1'b1}}) begin
                            n_fade_falling = !r_fade_falling;
                        end
                    end
                end
                default: n_duty = bmlc_pkg::DUTY_DARK;
            endcase

            // Toggle the blink phase once its time is up
            if (blinking) begin
                if (r_blink_lit && n_blink_age >= on_time) begin
                    n_blink_age = '0;
                    n_blink_lit = 1'b0;
                    n_duty      = bmlc_pkg::DUTY_DARK;
                end else if (!r_blink_lit && n_blink_age >= off_time) begin
                    n_blink_age = '0;
                    n_blink_lit = 1'b1;
                    n_duty      = bmlc_pkg::DUTY_FULL;
                end
            end
        end

        o_duty = n_duty;
    end

    // Commit the light state on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_lit    <= 1'b0;
            r_blink_age    <= '0;
            r_fade_level   <= '0;
            r_fade_falling <= 1'b0;
            r_fade_age     <= '0;
            r_duty         <= '0;
        end else if (i_advance) begin
            r_blink_lit    <= n_blink_lit;
            r_blink_age    <= n_blink_age;
            r_fade_level   <= n_fade_level;
            r_fade_falling <= n_fade_falling;
            r_fade_age     <= n_fade_age;
            r_duty         <= n_duty;
        end
    end

endmodule

`default_nettype wire

// ===== design/button_mode_led_controller.sv =====
// Top level of the button mode LED controller: config, input and result registers.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+--------------------------------
//   in      | sink      | i_in_valid / o_in_ready  | i_button_pressed
//   out     | source    | o_out_valid / i_out_ready| o_led_duty, o_current_mode,
//           |           |                          | o_asleep_flag, o_save_strobe,
//           |           |                          | o_save_value
//   cfg     | sink      | i_cfg_wr_en              | i_cfg_index, i_cfg_wdata
//
// One tick per cycle while the result is taken: a transaction is captured in the input
// register, and when the result register is free or draining, its button and light
// state updates land in the result register.
// Reset is synchronous, active low; it restores the register defaults, sleep and mode off.
// A stalled result register stops the state update; the input register then fills
// and holds o_in_ready low until the result is taken.
`default_nettype none

module button_mode_led_controller (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [bmlc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bmlc_pkg::PRESS_AGE_W-1:0]    i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_button_pressed,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [bmlc_pkg::BYTE_W-1:0]         o_led_duty,
    output logic      [bmlc_pkg::MODE_W-1:0]         o_current_mode,
    output logic                                     o_asleep_flag,
    output logic                                     o_save_strobe,
    output logic      [bmlc_pkg::MODE_W-1:0]         o_save_value
);

    logic [bmlc_pkg::BYTE_W-1:0]      r_debounce_ms;
    logic [bmlc_pkg::PRESS_AGE_W-1:0] r_long_press_ms;
    logic [bmlc_pkg::BYTE_W-1:0]      r_medium_level;
    logic [bmlc_pkg::BYTE_W-1:0]      r_low_level;
    logic [bmlc_pkg::BYTE_W-1:0]      r_fade_period_ms;
    logic [bmlc_pkg::BYTE_W-1:0]      r_fade_step;

    logic                             r_in_valid;
    logic                             r_in_pressed;
    logic                             advance;

    logic                             r_out_valid;
    logic [bmlc_pkg::BYTE_W-1:0]      r_out_duty;
    logic [bmlc_pkg::MODE_W-1:0]      r_out_mode;
    logic                             r_out_asleep;
    logic                             r_out_strobe;
    logic [bmlc_pkg::MODE_W-1:0]      r_out_saved;

    bmlc_pkg::t_btn_status            btn_status;
    logic [bmlc_pkg::BYTE_W-1:0]      light_duty;

    // Configuration registers; writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms    <= 8'd50;
            r_long_press_ms  <= 14'd1000;
            r_medium_level   <= 8'd100;
            r_low_level      <= 8'd25;
            r_fade_period_ms <= 8'd15;
            r_fade_step      <= 8'd5;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bmlc_pkg::CFG_DEBOUNCE:    r_debounce_ms    <= i_cfg_wdata[bmlc_pkg::BYTE_W-1:0];
                bmlc_pkg::CFG_LONG_PRESS:  r_long_press_ms  <= i_cfg_wdata;
                bmlc_pkg::CFG_MEDIUM:      r_medium_level   <= i_cfg_wdata[bmlc_pkg::BYTE_W-1:0];
                bmlc_pkg::CFG_LOW:         r_low_level      <= i_cfg_wdata[bmlc_pkg::BYTE_W-1:0];
                bmlc_pkg::CFG_FADE_PERIOD: r_fade_period_ms <= i_cfg_wdata[bmlc_pkg::BYTE_W-1:0];
                bmlc_pkg::CFG_FADE_STEP:   r_fade_step      <= i_cfg_wdata[bmlc_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance when a tick waits and the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_pressed <= i_button_pressed;
        end
    end

    bmlc_button u_button (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_pressed       (r_in_pressed),
        .i_debounce_ms   (r_debounce_ms),
        .i_long_press_ms (r_long_press_ms),
        .o_status        (btn_status)
    );

    bmlc_light u_light (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_status         (btn_status),
        .i_medium_level   (r_medium_level),
        .i_low_level      (r_low_level),
        .i_fade_period_ms (r_fade_period_ms),
        .i_fade_step      (r_fade_step),
        .o_duty           (light_duty)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_duty   <= light_duty;
            r_out_mode   <= btn_status.mode;
            r_out_asleep <= btn_status.sleeping;
            r_out_strobe <= btn_status.strobe;
            r_out_saved  <= btn_status.saved;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_led_duty     = r_out_duty;
    assign o_current_mode = r_out_mode;
    assign o_asleep_flag  = r_out_asleep;
    assign o_save_strobe  = r_out_strobe;
    assign o_save_value   = r_out_saved;

endmodule

`default_nettype wire
